FILE: hdl/tdmv_pkg.sv
// Shared types and constants of the temporal direct motion vector scaler.
package tdmv_pkg;

  // Vertical adjust codes of the co-located vector.
  localparam logic [1:0] MODE_KEEP   = 2'd0;
  localparam logic [1:0] MODE_HALF   = 2'd1;
  localparam logic [1:0] MODE_DOUBLE = 2'd2;

  // Distance scale factor arithmetic.
  localparam int DistNum     = 16384;
  localparam int UnityScale  = 256;
  localparam int ScaleRound  = 32;
  localparam int ScaleShift  = 6;
  localparam int ScaleMax    = 1023;
  localparam int ScaleMin    = -1024;
  localparam int MvRound     = 128;
  localparam int MvShift     = 8;

  // Divider: quotient bits and bits resolved per pipeline stage.
  localparam int QuoWidth  = 15;
  localparam int DIV_STEPS = 5;

  typedef struct packed {
    logic signed [31:0] poc_cur;
    logic signed [31:0] poc_fwd;
    logic signed [31:0] poc_bwd;
    logic               fwd_long_term;
    logic signed [15:0] col_mv_x;
    logic signed [15:0] col_mv_y;
    logic        [1:0]  mode;
  } tdmv_in_t;

  typedef struct packed {
    logic signed [10:0] scale_factor;
    logic signed [15:0] l0_mv_x;
    logic signed [15:0] l0_mv_y;
    logic signed [15:0] l1_mv_x;
    logic signed [15:0] l1_mv_y;
  } tdmv_out_t;

endpackage

FILE: hdl/tdmv_if.sv
// Valid/ready channel interfaces for the input and result transactions.
interface tdmv_in_if import tdmv_pkg::*; ();
  logic     valid;
  logic     ready;
  tdmv_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tdmv_out_if import tdmv_pkg::*; ();
  logic      valid;
  logic      ready;
  tdmv_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/tdmv_div_stage.sv
// Combinational slice of the restoring divider: a few quotient bits per stage.
module tdmv_div_stage import tdmv_pkg::*; (
  input  logic [7:0]           divisor_i,
  input  logic [7:0]           rem_i,
  input  logic [DIV_STEPS-1:0] num_bits_i,
  output logic [7:0]           rem_o,
  output logic [DIV_STEPS-1:0] quo_o
);

  logic [8:0] trial;
  logic [7:0] rem;

  // The remainder stays below the divisor (at most 128), so the shifted
  // trial value fits in nine bits.
  always_comb begin
    rem   = rem_i;
    trial = '0;
    quo_o = '0;
    for (int i = DIV_STEPS - 1; i >= 0; i--) begin
      trial = {rem, num_bits_i[i]};
      if (trial >= {1'b0, divisor_i}) begin
        trial    = trial - {1'b0, divisor_i};
        quo_o[i] = 1'b1;
      end
      rem = trial[7:0];
    end
    rem_o = rem;
  end

endmodule

FILE: hdl/temporal_direct_mv_scaler.sv
// Temporal direct motion vector scaler: eight-stage pipeline, one transaction per cycle
// while the output is not stalled, with the result shown on out_o from the last stage.
// Throughput is one transaction per clock unless out_o stalls; the three divider stages
// and the registered multipliers are fully pipelined, so nothing iterates.
// Each stage holds its item while its successor is full and stalled, so bubbles collapse.
// Reset (rst_ni low, asynchronous) clears the stage valid bits only.
module temporal_direct_mv_scaler import tdmv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  tdmv_in_if.sink           in_i,
  tdmv_out_if.source        out_o
);

  localparam int NumStages = 8;

  // Stage 1: clipped POC distances and the adjusted vertical component.
  typedef struct packed {
    logic signed [7:0]  tb;
    logic signed [7:0]  td;
    logic               unity;
    logic signed [15:0] mvx;
    logic signed [16:0] ady;
  } s1_t;

  // Stages 2 to 4: divider in flight, resolving the quotient of
  // (16384 + |td|/2) / |td| from the top bit down.
  typedef struct packed {
    logic signed [7:0]    tb;
    logic                 neg;
    logic                 unity;
    logic signed [15:0]   mvx;
    logic signed [16:0]   ady;
    logic [7:0]           divisor;
    logic [QuoWidth-1:0]  num;
    logic [7:0]           rem;
    logic [QuoWidth-1:0]  quo;
  } sdiv_t;

  // Stage 5: product of tb and the signed reciprocal tx.
  typedef struct packed {
    logic               unity;
    logic signed [15:0] mvx;
    logic signed [16:0] ady;
    logic signed [23:0] prod;
  } s5_t;

  // Stage 6: final scale factor.
  typedef struct packed {
    logic signed [10:0] sc;
    logic signed [15:0] mvx;
    logic signed [16:0] ady;
  } s6_t;

  // Stage 7: vector products.
  typedef struct packed {
    logic signed [10:0] sc;
    logic signed [15:0] mvx;
    logic signed [16:0] ady;
    logic signed [26:0] px;
    logic signed [27:0] py;
  } s7_t;

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] en;

  s1_t       s1_d, s1_q;
  sdiv_t     s2_d, s2_q, s3_d, s3_q, s4_d, s4_q;
  s5_t       s5_d, s5_q;
  s6_t       s6_d, s6_q;
  s7_t       s7_d, s7_q;
  tdmv_out_t s8_d, s8_q;

  // Saturates an exact 33-bit POC difference to the signed 8-bit range.
  function automatic logic signed [7:0] clip8(input logic signed [32:0] v);
    logic signed [7:0] r;
    if (v > 33'sd127) begin
      r = 8'sd127;
    end else if (v < -33'sd128) begin
      r = -8'sd128;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  // A stage may load when it is empty or when its content moves on in the
  // same cycle. The last stage is the output register.
  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || out_o.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: POC differences are taken exactly in 33 bits and then clipped.
  // The vertical adjust halves toward zero by adding one to negative values
  // before the arithmetic shift.
  // ---------------------------------------------------------------------
  logic signed [32:0] diff_td, diff_tb;
  logic signed [16:0] mvy_ext, mvy_bias;

  always_comb begin
    diff_td  = 33'(in_i.data.poc_bwd) - 33'(in_i.data.poc_fwd);
    diff_tb  = 33'(in_i.data.poc_cur) - 33'(in_i.data.poc_fwd);
    mvy_ext  = 17'(in_i.data.col_mv_y);
    mvy_bias = mvy_ext + $signed({16'd0, in_i.data.col_mv_y[15]});

    s1_d.tb    = clip8(diff_tb);
    s1_d.td    = clip8(diff_td);
    s1_d.unity = in_i.data.fwd_long_term || (clip8(diff_td) == 8'sd0);
    s1_d.mvx   = in_i.data.col_mv_x;
    unique case (in_i.data.mode)
      MODE_HALF:   s1_d.ady = mvy_bias >>> 1;
      MODE_DOUBLE: s1_d.ady = mvy_ext <<< 1;
      MODE_KEEP:   s1_d.ady = mvy_ext;
      default:     s1_d.ady = mvy_ext;
    endcase
  end

  // ---------------------------------------------------------------------
  // Stage 2: divisor magnitude, rounded numerator, first quotient bits.
  // A zero divisor gives a meaningless quotient that the unity flag masks.
  // ---------------------------------------------------------------------
  logic [7:0]          div_a;
  logic [QuoWidth-1:0] div_num;
  logic [7:0]          rem2, rem3, rem4;
  logic [DIV_STEPS-1:0] quo2, quo3, quo4;

  always_comb begin
    div_a   = s1_q.td[7] ? 8'(-s1_q.td) : 8'(s1_q.td);
    div_num = QuoWidth'(DistNum) + QuoWidth'(div_a >> 1);
  end

  tdmv_div_stage u_div_hi (
    .divisor_i  (div_a),
    .rem_i      (8'd0),
    .num_bits_i (div_num[QuoWidth-1 -: DIV_STEPS]),
    .rem_o      (rem2),
    .quo_o      (quo2)
  );

  always_comb begin
    s2_d.tb      = s1_q.tb;
    s2_d.neg     = s1_q.td[7];
    s2_d.unity   = s1_q.unity;
    s2_d.mvx     = s1_q.mvx;
    s2_d.ady     = s1_q.ady;
    s2_d.divisor = div_a;
    s2_d.num     = div_num;
    s2_d.rem     = rem2;
    s2_d.quo     = '0;
    s2_d.quo[QuoWidth-1 -: DIV_STEPS] = quo2;
  end

  // Stage 3: middle quotient bits.
  tdmv_div_stage u_div_mid (
    .divisor_i  (s2_q.divisor),
    .rem_i      (s2_q.rem),
    .num_bits_i (s2_q.num[QuoWidth-1-DIV_STEPS -: DIV_STEPS]),
    .rem_o      (rem3),
    .quo_o      (quo3)
  );

  always_comb begin
    s3_d     = s2_q;
    s3_d.rem = rem3;
    s3_d.quo[QuoWidth-1-DIV_STEPS -: DIV_STEPS] = quo3;
  end

  // Stage 4: low quotient bits.
  tdmv_div_stage u_div_lo (
    .divisor_i  (s3_q.divisor),
    .rem_i      (s3_q.rem),
    .num_bits_i (s3_q.num[QuoWidth-1-2*DIV_STEPS -: DIV_STEPS]),
    .rem_o      (rem4),
    .quo_o      (quo4)
  );

  always_comb begin
    s4_d     = s3_q;
    s4_d.rem = rem4;
    s4_d.quo[QuoWidth-1-2*DIV_STEPS -: DIV_STEPS] = quo4;
  end

  // ---------------------------------------------------------------------
  // Stage 5: the numerator is positive, so truncation toward zero is the
  // magnitude quotient with the divisor's sign applied. Then tb * tx.
  // ---------------------------------------------------------------------
  logic signed [15:0] tx_mag, tx;

  always_comb begin
    tx_mag      = $signed({1'b0, s4_q.quo});
    tx          = s4_q.neg ? -tx_mag : tx_mag;
    s5_d.unity  = s4_q.unity;
    s5_d.mvx    = s4_q.mvx;
    s5_d.ady    = s4_q.ady;
    s5_d.prod   = 24'(s4_q.tb) * 24'(tx);
  end

  // Stage 6: round, floor shift and clip to the scale factor range.
  logic signed [23:0] sc_sum, sc_shr;

  always_comb begin
    sc_sum = s5_q.prod + 24'sd32;
    sc_shr = sc_sum >>> ScaleShift;
    if (s5_q.unity) begin
      s6_d.sc = 11'(UnityScale);
    end else if (sc_shr > 24'(ScaleMax)) begin
      s6_d.sc = 11'(ScaleMax);
    end else if (sc_shr < 24'(ScaleMin)) begin
      s6_d.sc = 11'(ScaleMin);
    end else begin
      s6_d.sc = sc_shr[10:0];
    end
    s6_d.mvx = s5_q.mvx;
    s6_d.ady = s5_q.ady;
  end

  // Stage 7: scale both vector components.
  always_comb begin
    s7_d.sc  = s6_q.sc;
    s7_d.mvx = s6_q.mvx;
    s7_d.ady = s6_q.ady;
    s7_d.px  = 27'(s6_q.sc) * 27'(s6_q.mvx);
    s7_d.py  = 28'(s6_q.sc) * 28'(s6_q.ady);
  end

  // ---------------------------------------------------------------------
  // Stage 8: round and floor shift by eight, keep the low 16 bits, and form
  // the list1 vectors by wrapping subtraction.
  // ---------------------------------------------------------------------
  logic signed [26:0] px_rnd;
  logic signed [27:0] py_rnd;
  logic signed [15:0] l0x, l0y;

  always_comb begin
    px_rnd = s7_q.px + 27'(MvRound);
    py_rnd = s7_q.py + 28'(MvRound);
    l0x    = px_rnd[MvShift +: 16];
    l0y    = py_rnd[MvShift +: 16];
    s8_d.scale_factor = s7_q.sc;
    s8_d.l0_mv_x      = l0x;
    s8_d.l0_mv_y      = l0y;
    s8_d.l1_mv_x      = l0x - s7_q.mvx;
    s8_d.l1_mv_y      = l0y - s7_q.ady[15:0];
  end

  // Payload registers, loaded with their stage enable.
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_q <= s1_d;
    end
    if (en[1]) begin
      s2_q <= s2_d;
    end
    if (en[2]) begin
      s3_q <= s3_d;
    end
    if (en[3]) begin
      s4_q <= s4_d;
    end
    if (en[4]) begin
      s5_q <= s5_d;
    end
    if (en[5]) begin
      s6_q <= s6_d;
    end
    if (en[6]) begin
      s7_q <= s7_d;
    end
    if (en[7]) begin
      s8_q <= s8_d;
    end
  end

  assign out_o.valid = vld_q[NumStages-1];
  assign out_o.data  = s8_q;

endmodule

FILE: tb/temporal_direct_mv_scaler_tb.sv
// Self-checking testbench of the temporal direct motion vector scaler.
module temporal_direct_mv_scaler_tb;
  import tdmv_pkg::*;

  // Cycle limit of the whole run, checked by the watchdog.
  localparam int CycleLimit  = 200000;
  // The pipeline is eight deep; these idle cycles after the last result catch any stray one.
  localparam int DrainCycles = 16;
  localparam int RandomItems = 800;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         PocMax      = 32'sh7fff_ffff;
  localparam int         PocMin      = 32'sh8000_0000;

  // Keeps the expected direct vectors of every accepted request in order and
  // compares each result transaction against the oldest of them.
  class direct_mv_tracker;
    tdmv_out_t pending_mvs[$];
    int        mismatches = 0;

    // Saturates an exact POC difference to the 8-bit signed range.
    function longint sat_poc_diff(longint d);
      if (d > 127) return 127;
      if (d < -128) return -128;
      return d;
    endfunction

    function tdmv_out_t predict_direct_mv(tdmv_in_t t);
      longint    td, tb, tx, scale, mvx, adj_y, l0x, l0y, l1x, l1y;
      tdmv_out_t r;
      td = sat_poc_diff(longint'(t.poc_bwd) - longint'(t.poc_fwd));
      if (td == 0 || t.fwd_long_term) begin
        scale = UnityScale;
      end else begin
        tb    = sat_poc_diff(longint'(t.poc_cur) - longint'(t.poc_fwd));
        // SystemVerilog division truncates toward zero, as the scheme needs.
        tx    = (DistNum + ((td < 0 ? -td : td) >> 1)) / td;
        scale = (tb * tx + ScaleRound) >>> ScaleShift;
        if (scale > ScaleMax) scale = ScaleMax;
        if (scale < ScaleMin) scale = ScaleMin;
      end
      mvx = longint'(t.col_mv_x);
      case (t.mode)
        MODE_HALF: begin
          adj_y = longint'(t.col_mv_y) / 2;
        end
        MODE_DOUBLE: begin
          adj_y = longint'(t.col_mv_y) * 2;
        end
        default: begin
          adj_y = longint'(t.col_mv_y);
        end
      endcase
      l0x = (scale * mvx + MvRound) >>> MvShift;
      l0y = (scale * adj_y + MvRound) >>> MvShift;
      // Only the low 16 bits survive, so the wrap of L0 can be left to the end.
      l1x = l0x - mvx;
      l1y = l0y - adj_y;
      r.scale_factor = scale[10:0];
      r.l0_mv_x      = l0x[15:0];
      r.l0_mv_y      = l0y[15:0];
      r.l1_mv_x      = l1x[15:0];
      r.l1_mv_y      = l1y[15:0];
      return r;
    endfunction

    function void note_request(tdmv_in_t t);
      pending_mvs.push_back(predict_direct_mv(t));
    endfunction

    function void check_result(tdmv_out_t got);
      tdmv_out_t want;
      if (pending_mvs.size() == 0) begin
        $error("result transaction with no request outstanding");
        mismatches++;
        return;
      end
      want = pending_mvs.pop_front();
      if (got.scale_factor !== want.scale_factor) begin
        $error("scale_factor: expected %0d, got %0d", want.scale_factor, got.scale_factor);
        mismatches++;
      end
      if (got.l0_mv_x !== want.l0_mv_x) begin
        $error("l0_mv_x: expected %0d, got %0d", want.l0_mv_x, got.l0_mv_x);
        mismatches++;
      end
      if (got.l0_mv_y !== want.l0_mv_y) begin
        $error("l0_mv_y: expected %0d, got %0d", want.l0_mv_y, got.l0_mv_y);
        mismatches++;
      end
      if (got.l1_mv_x !== want.l1_mv_x) begin
        $error("l1_mv_x: expected %0d, got %0d", want.l1_mv_x, got.l1_mv_x);
        mismatches++;
      end
      if (got.l1_mv_y !== want.l1_mv_y) begin
        $error("l1_mv_y: expected %0d, got %0d", want.l1_mv_y, got.l1_mv_y);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  tdmv_in_if  in_if();
  tdmv_out_if out_if();

  temporal_direct_mv_scaler i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  direct_mv_tracker tracker = new();

  // Percent chance, per cycle, that the sender holds back or the receiver
  // stalls. The main sequence changes them between phases.
  int          send_gap_pct   = 23;
  int          recv_stall_pct = 47;
  int unsigned cycle_count    = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver drops ready at random. Driving it in one process keeps a
  // single writer and a known value from time zero.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Both channels are observed at the clock edge, before any nonblocking
  // update of that edge lands, so handshakes are seen exactly as the block
  // sees them. A request accepted at this edge cannot leave until it has passed through
  // the stage registers down to the output register, so the order of the two calls does not matter.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) tracker.note_request(in_if.data);
      if (out_if.valid && out_if.ready) tracker.check_result(out_if.data);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[temporal_direct_mv_scaler] ERROR");
      $finish;
    end
  end

  // Offers one request and returns at the edge where it is taken. Before the
  // offer the sender may sit idle for a random number of cycles. Valid is
  // written at most once per edge, so a back-to-back stream keeps it high.
  task automatic send_request(tdmv_in_t t);
    while ($urandom_range(99) < send_gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= t;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic send_fields(int cur, int fwd, int bwd, bit lt, shortint mx, shortint my,
                             logic [1:0] md);
    tdmv_in_t t;
    t.poc_cur       = cur;
    t.poc_fwd       = fwd;
    t.poc_bwd       = bwd;
    t.fwd_long_term = lt;
    t.col_mv_x      = mx;
    t.col_mv_y      = my;
    t.mode          = md;
    send_request(t);
  endtask

  // A POC close to one end of the 32-bit range, so that differences between
  // such values overflow 32 bits and must saturate.
  function automatic int edge_poc();
    return $urandom_range(1) ? PocMax - int'($urandom_range(200))
                             : PocMin + int'($urandom_range(200));
  endfunction

  // Most requests model real pictures with the three POCs close together; the
  // rest use random or near-extreme POCs. Vectors are moderate or full range.
  function automatic tdmv_in_t random_request();
    tdmv_in_t    t;
    int unsigned kind;
    kind    = $urandom_range(9);
    t.poc_fwd = $urandom;
    if (kind < 7) begin
      t.poc_bwd = t.poc_fwd + (int'($urandom_range(300)) - 150);
      t.poc_cur = t.poc_fwd + (int'($urandom_range(300)) - 150);
    end else if (kind < 9) begin
      t.poc_bwd = $urandom;
      t.poc_cur = $urandom;
    end else begin
      t.poc_fwd = edge_poc();
      t.poc_bwd = edge_poc();
      t.poc_cur = edge_poc();
    end
    t.fwd_long_term = ($urandom_range(7) == 0);
    if ($urandom_range(1)) begin
      t.col_mv_x = 16'($urandom);
      t.col_mv_y = 16'($urandom);
    end else begin
      t.col_mv_x = 16'(int'($urandom_range(1024)) - 512);
      t.col_mv_y = 16'(int'($urandom_range(1024)) - 512);
    end
    t.mode = 2'($urandom_range(3));
    return t;
  endfunction

  initial begin
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests. Equal forward and backward POCs give a zero
    // distance, which forces the unity factor.
    send_fields(0, 0, 0, 1'b0, 0, 0, MODE_KEEP);
    send_fields(5, 0, 0, 1'b0, 100, -100, MODE_HALF);
    // A long-term reference also forces unity despite a nonzero distance.
    send_fields(2, 0, 4, 1'b1, 300, -301, MODE_DOUBLE);
    // Distance of one with the largest temporal offset clips the factor high,
    // and a negative distance clips it low; the doubled vector then wraps.
    send_fields(127, 0, 1, 1'b0, 32767, -32768, MODE_KEEP);
    send_fields(127, 0, -1, 1'b0, 32767, 32767, MODE_DOUBLE);
    send_fields(-128, 0, 127, 1'b0, -32768, -32767, MODE_HALF);
    send_fields(127, 0, -128, 1'b0, 1234, -5, MODE_HALF);
    send_fields(-3, 0, 2, 1'b0, -32768, 32767, MODE_KEEP);
    send_fields(0, 0, -3, 1'b0, 777, -778, MODE_DOUBLE);
    // POC differences that overflow 32 bits must saturate rather than wrap.
    send_fields(PocMin, PocMin, PocMax, 1'b0, 512, 512, MODE_KEEP);
    send_fields(PocMax, PocMin, PocMax, 1'b0, -32768, -32768, MODE_DOUBLE);
    send_fields(PocMin, PocMax, PocMin, 1'b0, 32767, -1, MODE_HALF);
    send_fields(PocMax, PocMax - 2, PocMax, 1'b0, 32767, 32767, MODE_DOUBLE);
    // Halving rounds toward zero, so minus one becomes zero.
    send_fields(3, 1, 5, 1'b0, -1, -1, MODE_HALF);
    // The unused mode code behaves like keep.
    send_fields(1, 0, 2, 1'b0, -7, -3, MODE_UNUSED);
    send_fields(1, 0, 2, 1'b0, -32768, -32768, MODE_UNUSED);

    // First random phase: sender lightly gapped, receiver heavily stalled.
    repeat (RandomItems / 3) send_request(random_request());

    // Hold the sender until the pipeline has delivered every result.
    in_if.valid <= 1'b0;
    do @(posedge clk); while (tracker.pending_mvs.size() != 0);

    // Second phase swaps the pressure; the third runs at full rate.
    send_gap_pct   = 47;
    recv_stall_pct = 23;
    repeat (RandomItems / 3) send_request(random_request());
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    repeat (RandomItems - 2 * (RandomItems / 3)) send_request(random_request());

    in_if.valid <= 1'b0;
    do @(posedge clk); while (tracker.pending_mvs.size() != 0);
    repeat (DrainCycles) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.pending_mvs.size() == 0) begin
      $display("[temporal_direct_mv_scaler] OK");
    end else begin
      $display("[temporal_direct_mv_scaler] ERROR");
    end
    $finish;
  end

endmodule
